FILE: design/vector3_normalize_unit_macros.svh
// Assertion macros for the vector3_normalize_unit checker.
// Clocked on clk_i, disabled while rst_ni is low.
`ifndef VECTOR3_NORMALIZE_UNIT_MACROS_SVH
`define VECTOR3_NORMALIZE_UNIT_MACROS_SVH

`define VNU_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`define VNU_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

FILE: design/vnu_pkg.sv
// Shared widths and cell payload types for the vector normalize pipeline.
// No dependencies.
package vnu_pkg;

  localparam int unsigned CompW     = 16;
  localparam int unsigned FracW     = 14;
  localparam int unsigned UnitW     = FracW + 2;
  localparam int unsigned SumW      = 2 * CompW;
  localparam int unsigned QuoW      = 2 * FracW + 1;
  localparam int unsigned DivSteps  = QuoW;
  localparam int unsigned RootW     = CompW;
  localparam int unsigned SqrtSteps = RootW;
  localparam int unsigned RemW      = RootW + 2;
  localparam int unsigned Lanes     = 3;
  localparam int unsigned SqLanes   = Lanes + 1;
  localparam int unsigned PipeDepth = 2 + DivSteps + SqrtSteps;

  typedef logic [SumW-1:0] sum_t;

  typedef struct packed {
    logic [SumW-1:0]             den;
    logic [Lanes-1:0][SumW:0]    rem;
    logic [Lanes-1:0][QuoW-1:0]  quo;
  } div_t;

  typedef struct packed {
    logic [SumW-1:0]  val;
    logic [RemW-1:0]  rem;
    logic [RootW-1:0] root;
  } sqrt_t;

  typedef struct packed {
    logic [Lanes-1:0] neg;
    logic             zero;
  } side_t;

endpackage

FILE: design/vnu_if.sv
// Valid/ready channel interfaces for vector input and normalized output.
// Depends on vnu_pkg.
interface vnu_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [vnu_pkg::CompW-1:0]  comp_x;
  logic signed [vnu_pkg::CompW-1:0]  comp_y;
  logic signed [vnu_pkg::CompW-1:0]  comp_z;
  modport source (output valid, comp_x, comp_y, comp_z, input ready);
  modport sink (input valid, comp_x, comp_y, comp_z, output ready);
endinterface

interface vnu_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [vnu_pkg::UnitW-1:0]  unit_x;
  logic signed [vnu_pkg::UnitW-1:0]  unit_y;
  logic signed [vnu_pkg::UnitW-1:0]  unit_z;
  logic        [vnu_pkg::CompW-1:0]  vec_length;
  logic                              zero_length;
  modport source (output valid, unit_x, unit_y, unit_z, vec_length, zero_length,
                  input ready);
  modport sink (input valid, unit_x, unit_y, unit_z, vec_length, zero_length,
                output ready);
endinterface

FILE: design/vnu_div_cell.sv
// One restoring-division cell: one quotient bit per lane, shared divisor.
// Depends on vnu_pkg.
module vnu_div_cell (
  input  logic           clk_i,
  input  logic           en_i,
  input  vnu_pkg::div_t  cell_i,
  output vnu_pkg::div_t  cell_o
);

  vnu_pkg::div_t cell_d, cell_q;

  always_comb begin
    logic [vnu_pkg::SumW:0] r;
    logic                   ge;
    cell_d     = cell_i;
    for (int l = 0; l < vnu_pkg::Lanes; l++) begin
      ge = cell_i.rem[l] >= {1'b0, cell_i.den};
      r  = ge ? cell_i.rem[l] - {1'b0, cell_i.den} : cell_i.rem[l];
      cell_d.rem[l] = {r[vnu_pkg::SumW-1:0], 1'b0};
      cell_d.quo[l] = {cell_i.quo[l][vnu_pkg::QuoW-2:0], ge};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

FILE: design/vnu_sqrt_cell.sv
// One digit-by-digit square root cell: consumes two radicand bits, yields one root bit.
// Depends on vnu_pkg.
module vnu_sqrt_cell (
  input  logic            clk_i,
  input  logic            en_i,
  input  vnu_pkg::sqrt_t  cell_i,
  output vnu_pkg::sqrt_t  cell_o
);

  localparam int unsigned CurW = vnu_pkg::RemW + 2;

  vnu_pkg::sqrt_t cell_d, cell_q;

  always_comb begin
    logic [CurW-1:0] cur;
    logic [CurW-1:0] trial;
    cur   = {cell_i.rem, cell_i.val[vnu_pkg::SumW-1 -: 2]};
    trial = {{(CurW-vnu_pkg::RootW-2){1'b0}}, cell_i.root, 2'b01};
    cell_d.val = {cell_i.val[vnu_pkg::SumW-3:0], 2'b00};
    if (cur >= trial) begin
      cell_d.rem  = vnu_pkg::RemW'(cur - trial);
      cell_d.root = {cell_i.root[vnu_pkg::RootW-2:0], 1'b1};
    end else begin
      cell_d.rem  = vnu_pkg::RemW'(cur);
      cell_d.root = {cell_i.root[vnu_pkg::RootW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

FILE: design/vector3_normalize_unit.sv
// Pipeline from input transfer to result: magnitude, square, 29 division
// cells, 16 square root cells, output register. Throughput: one vector per cycle;
// the whole pipeline advances together and holds while a result waits.
// Reset: valid flags cleared asynchronously; data registers are not reset.
// Depends on vnu_pkg, vnu_if, vnu_div_cell, vnu_sqrt_cell.
module vector3_normalize_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  vnu_in_if.sink     in_i,
  vnu_out_if.source  out_o
);

  logic en;
  logic [vnu_pkg::PipeDepth-1:0] vld_q;
  vnu_pkg::side_t side_q [vnu_pkg::PipeDepth];
  logic [vnu_pkg::CompW-1:0] mag_d [vnu_pkg::Lanes];
  logic [vnu_pkg::CompW-1:0] mag_q [vnu_pkg::Lanes];
  vnu_pkg::sum_t sq_q [vnu_pkg::Lanes];
  vnu_pkg::div_t div_w [vnu_pkg::DivSteps+1];
  vnu_pkg::sqrt_t sqrt_w [vnu_pkg::SqrtSteps+1][vnu_pkg::SqLanes];
  logic signed [vnu_pkg::CompW-1:0] comp [vnu_pkg::Lanes];
  vnu_pkg::side_t side_in;
  logic out_vld_q;
  logic signed [vnu_pkg::UnitW-1:0] unit_d [vnu_pkg::Lanes];
  logic signed [vnu_pkg::UnitW-1:0] unit_q [vnu_pkg::Lanes];
  logic [vnu_pkg::CompW-1:0] len_q;
  logic zero_q;

  assign en = !out_vld_q || out_o.ready;
  assign in_i.ready = en;

  assign comp[0] = in_i.comp_x;
  assign comp[1] = in_i.comp_y;
  assign comp[2] = in_i.comp_z;

  always_comb begin
    for (int l = 0; l < vnu_pkg::Lanes; l++) begin
      side_in.neg[l] = comp[l][vnu_pkg::CompW-1];
      mag_d[l] = side_in.neg[l] ? vnu_pkg::CompW'(-comp[l]) : vnu_pkg::CompW'(comp[l]);
    end
    side_in.zero = (comp[0] == '0) && (comp[1] == '0) && (comp[2] == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      vld_q     <= {vld_q[vnu_pkg::PipeDepth-2:0], in_i.valid};
      out_vld_q <= vld_q[vnu_pkg::PipeDepth-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= side_in;
      for (int p = 1; p < vnu_pkg::PipeDepth; p++) begin
        side_q[p] <= side_q[p-1];
      end
      for (int l = 0; l < vnu_pkg::Lanes; l++) begin
        mag_q[l] <= mag_d[l];
        sq_q[l]  <= mag_q[l] * mag_q[l];
      end
    end
  end

  always_comb begin
    div_w[0].den = sq_q[0] + sq_q[1] + sq_q[2];
    for (int l = 0; l < vnu_pkg::Lanes; l++) begin
      div_w[0].rem[l] = {1'b0, sq_q[l]};
      div_w[0].quo[l] = '0;
    end
  end

  for (genvar k = 0; k < vnu_pkg::DivSteps; k++) begin : g_div
    vnu_div_cell u_cell (
      .clk_i  (clk_i),
      .en_i   (en),
      .cell_i (div_w[k]),
      .cell_o (div_w[k+1])
    );
  end

  always_comb begin
    for (int l = 0; l < vnu_pkg::Lanes; l++) begin
      sqrt_w[0][l].val  = vnu_pkg::SumW'(div_w[vnu_pkg::DivSteps].quo[l]);
      sqrt_w[0][l].rem  = '0;
      sqrt_w[0][l].root = '0;
    end
    sqrt_w[0][vnu_pkg::Lanes].val  = div_w[vnu_pkg::DivSteps].den;
    sqrt_w[0][vnu_pkg::Lanes].rem  = '0;
    sqrt_w[0][vnu_pkg::Lanes].root = '0;
  end

  for (genvar s = 0; s < vnu_pkg::SqrtSteps; s++) begin : g_sqrt
    for (genvar l = 0; l < vnu_pkg::SqLanes; l++) begin : g_lane
      vnu_sqrt_cell u_cell (
        .clk_i  (clk_i),
        .en_i   (en),
        .cell_i (sqrt_w[s][l]),
        .cell_o (sqrt_w[s+1][l])
      );
    end
  end

  always_comb begin
    logic [vnu_pkg::UnitW-1:0] m;
    for (int l = 0; l < vnu_pkg::Lanes; l++) begin
      m = {1'b0, sqrt_w[vnu_pkg::SqrtSteps][l].root[vnu_pkg::UnitW-2:0]};
      if (side_q[vnu_pkg::PipeDepth-1].zero) begin
        unit_d[l] = '0;
      end else if (side_q[vnu_pkg::PipeDepth-1].neg[l]) begin
        unit_d[l] = -m;
      end else begin
        unit_d[l] = m;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int l = 0; l < vnu_pkg::Lanes; l++) begin
        unit_q[l] <= unit_d[l];
      end
      len_q  <= side_q[vnu_pkg::PipeDepth-1].zero ? '0 :
                sqrt_w[vnu_pkg::SqrtSteps][vnu_pkg::Lanes].root;
      zero_q <= side_q[vnu_pkg::PipeDepth-1].zero;
    end
  end

  assign out_o.valid       = out_vld_q;
  assign out_o.unit_x      = unit_q[0];
  assign out_o.unit_y      = unit_q[1];
  assign out_o.unit_z      = unit_q[2];
  assign out_o.vec_length  = len_q;
  assign out_o.zero_length = zero_q;

endmodule

FILE: design/vnu_checker.sv
// Port-level checks for vector3_normalize_unit, attached by bind.
// Depends on vnu_pkg and vector3_normalize_unit_macros.svh.
`include "vector3_normalize_unit_macros.svh"

module vnu_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [vnu_pkg::UnitW-1:0]    unit_x,
  input logic [vnu_pkg::UnitW-1:0]    unit_y,
  input logic [vnu_pkg::UnitW-1:0]    unit_z,
  input logic [vnu_pkg::CompW-1:0]    vec_length,
  input logic                         zero_length
);

  `VNU_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(vec_length), "stalled result changed")
  `VNU_ASSERT(a_ready, in_ready == (!out_valid || out_ready), "input ready not tied to output slot")
  `VNU_ASSERT(a_zero, (out_valid && zero_length) |-> (vec_length == '0 && unit_x == '0 && unit_y == '0 && unit_z == '0), "zero vector with nonzero result")
  `VNU_ASSERT(a_nonzero, (out_valid && !zero_length) |-> (vec_length != '0), "nonzero vector with zero length")

endmodule

bind vector3_normalize_unit vnu_checker u_vnu_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready    (in_i.ready),
  .out_valid   (out_o.valid),
  .out_ready   (out_o.ready),
  .unit_x      (out_o.unit_x),
  .unit_y      (out_o.unit_y),
  .unit_z      (out_o.unit_z),
  .vec_length  (out_o.vec_length),
  .zero_length (out_o.zero_length)
);
